// ===== hdl/m3p_pkg.sv =====
package m3p_pkg;

  // Width of every matrix entry and of the exponent on the ports.
  localparam int FIELD_WIDTH = 32;

  // Default internal widths.
  localparam int ENTRY_WIDTH_DEF = 32;
  localparam int EXP_WIDTH_DEF   = 32;

  // Widest operand that the shared multipliers take.
  localparam int PART_WIDTH = 32;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] m00;
    logic signed [FIELD_WIDTH-1:0] m01;
    logic signed [FIELD_WIDTH-1:0] m02;
    logic signed [FIELD_WIDTH-1:0] m10;
    logic signed [FIELD_WIDTH-1:0] m11;
    logic signed [FIELD_WIDTH-1:0] m12;
    logic signed [FIELD_WIDTH-1:0] m20;
    logic signed [FIELD_WIDTH-1:0] m21;
    logic signed [FIELD_WIDTH-1:0] m22;
    logic        [FIELD_WIDTH-1:0] exponent;
  } request_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] p00;
    logic signed [FIELD_WIDTH-1:0] p01;
    logic signed [FIELD_WIDTH-1:0] p02;
    logic signed [FIELD_WIDTH-1:0] p10;
    logic signed [FIELD_WIDTH-1:0] p11;
    logic signed [FIELD_WIDTH-1:0] p12;
    logic signed [FIELD_WIDTH-1:0] p20;
    logic signed [FIELD_WIDTH-1:0] p21;
    logic signed [FIELD_WIDTH-1:0] p22;
  } result_t;

endpackage

// ===== hdl/m3p_mul.sv =====
module m3p_mul #(
  parameter int ENTRY_WIDTH = m3p_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [8:0][ENTRY_WIDTH-1:0] a,
  input  logic [8:0][ENTRY_WIDTH-1:0] b,
  output logic                        done,
  output logic [8:0][ENTRY_WIDTH-1:0] result
);
  import m3p_pkg::*;

  // Operand slice width, and the number of partial products per term.
  // Above PART_WIDTH bits, the low ENTRY_WIDTH bits of a*b need
  // lo*lo, lo*hi and hi*lo; the hi*hi product falls off the top.
  localparam int PW  = (ENTRY_WIDTH > PART_WIDTH) ? PART_WIDTH : ENTRY_WIDTH;
  localparam int NPP = (ENTRY_WIDTH > PW) ? 3 : 1;

  logic       run;
  logic [1:0] k;
  logic [1:0] pp;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      k    <= '0;
      pp   <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        k   <= '0;
        pp  <= '0;
      end else if (run) begin
        if (pp == 2'(NPP - 1)) begin
          pp <= '0;
          if (k == 2'd2) begin
            run  <= 1'b0;
            done <= 1'b1;
          end else begin
            k <= k + 2'd1;
          end
        end else begin
          pp <= pp + 2'd1;
        end
      end
    end
  end

  // Nine lanes, one per result entry; lane (i, j) adds a[i][k] * b[k][j].
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      logic [3:0]             a_idx;
      logic [3:0]             b_idx;
      logic [2*PW-1:0]        a_x;
      logic [2*PW-1:0]        b_x;
      logic [PW-1:0]          a_part;
      logic [PW-1:0]          b_part;
      logic [2*PW-1:0]        pp_prod;
      logic [ENTRY_WIDTH-1:0] term;
      logic [ENTRY_WIDTH-1:0] sum;

      assign a_idx   = 4'(3 * i) + {2'b00, k};
      assign b_idx   = ({2'b00, k} * 4'd3) + 4'(j);
      assign a_x     = (2*PW)'(a[a_idx]);
      assign b_x     = (2*PW)'(b[b_idx]);
      assign a_part  = (pp == 2'd2) ? a_x[2*PW-1:PW] : a_x[PW-1:0];
      assign b_part  = (pp == 2'd1) ? b_x[2*PW-1:PW] : b_x[PW-1:0];
      assign pp_prod = (2*PW)'(a_part) * (2*PW)'(b_part);
      assign term    = (pp == 2'd0) ? ENTRY_WIDTH'(pp_prod)
                                    : ENTRY_WIDTH'({pp_prod, {PW{1'b0}}});

      always_ff @(posedge clk) begin
        if (go) begin
          sum <= '0;
        end else if (run) begin
          sum <= sum + term;
        end
      end

      assign result[3*i + j] = sum;
    end
  end

endmodule

// ===== hdl/matrix3_power_by_squaring_top.sv =====
// Raises a 3x3 matrix of signed entries to an unsigned power by square-and-multiply,
// with all arithmetic wrapping in two's complement at ENTRY_WIDTH bits. A transaction
// is accepted on a clock edge where start is high and busy is low; busy then stays
// high until the result is out. The result appears on the result port for exactly one
// cycle, marked by done, and the receiver cannot stall it, so it must take it then.
// An item takes a variable number of cycles set by the exponent: the exponent is
// scanned from its low bit, and each 3x3 product runs on nine shared multiply-add
// lanes, where the 32x32 multipliers build each term from one partial product for
// entries up to 32 bits and from three above. A set exponent bit costs one product
// into the result and, unless it is the top set bit, one squaring; a clear bit
// costs one squaring. Each bit also passes through the check and square-decision
// states of the sequencer; exponent zero finishes with the identity as its result.
module matrix3_power_by_squaring_top #(
  parameter int ENTRY_WIDTH = m3p_pkg::ENTRY_WIDTH_DEF,
  parameter int EXP_WIDTH   = m3p_pkg::EXP_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  m3p_pkg::request_t  request,
  output logic               done,
  output m3p_pkg::result_t   result
);
  import m3p_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a transaction
  localparam logic [2:0] ST_CHECK = 3'd1;  // look at the low exponent bit
  localparam logic [2:0] ST_ACC   = 3'd2;  // result times base in flight
  localparam logic [2:0] ST_SQCHK = 3'd3;  // decide whether to square
  localparam logic [2:0] ST_SQ    = 3'd4;  // base squared in flight

  logic [2:0]                  state;
  logic [EXP_WIDTH-1:0]        e;
  logic [8:0][ENTRY_WIDTH-1:0] base;
  logic [8:0][ENTRY_WIDTH-1:0] acc;
  logic                        squaring;
  logic                        mul_go;
  logic                        mul_done;
  logic [8:0][ENTRY_WIDTH-1:0] mul_a;
  logic [8:0][ENTRY_WIDTH-1:0] mul_res;
  logic [8:0][ENTRY_WIDTH-1:0] load;

  assign busy = (state != ST_IDLE);

  // Input entries are sign-extended or truncated to the working width.
  assign load[0] = ENTRY_WIDTH'(request.m00);
  assign load[1] = ENTRY_WIDTH'(request.m01);
  assign load[2] = ENTRY_WIDTH'(request.m02);
  assign load[3] = ENTRY_WIDTH'(request.m10);
  assign load[4] = ENTRY_WIDTH'(request.m11);
  assign load[5] = ENTRY_WIDTH'(request.m12);
  assign load[6] = ENTRY_WIDTH'(request.m20);
  assign load[7] = ENTRY_WIDTH'(request.m21);
  assign load[8] = ENTRY_WIDTH'(request.m22);

  // The shared product unit always takes the base on its right side; the left side
  // is the base when squaring and the running result otherwise.
  assign mul_a = squaring ? base : acc;

  m3p_mul #(
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .go     (mul_go),
    .a      (mul_a),
    .b      (base),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      mul_go   <= 1'b0;
      squaring <= 1'b0;
    end else begin
      done   <= 1'b0;
      mul_go <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            base <= load;
            for (int n = 0; n < 9; n++) begin
              acc[n] <= (n % 4 == 0) ? ENTRY_WIDTH'(1) : '0;
            end
            e     <= EXP_WIDTH'(request.exponent);
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (e == '0) begin
            // All bits consumed: the running result is the answer.
            result.p00 <= FIELD_WIDTH'($signed(acc[0]));
            result.p01 <= FIELD_WIDTH'($signed(acc[1]));
            result.p02 <= FIELD_WIDTH'($signed(acc[2]));
            result.p10 <= FIELD_WIDTH'($signed(acc[3]));
            result.p11 <= FIELD_WIDTH'($signed(acc[4]));
            result.p12 <= FIELD_WIDTH'($signed(acc[5]));
            result.p20 <= FIELD_WIDTH'($signed(acc[6]));
            result.p21 <= FIELD_WIDTH'($signed(acc[7]));
            result.p22 <= FIELD_WIDTH'($signed(acc[8]));
            done  <= 1'b1;
            state <= ST_IDLE;
          end else if (e[0]) begin
            squaring <= 1'b0;
            mul_go   <= 1'b1;
            state    <= ST_ACC;
          end else begin
            e     <= e >> 1;
            state <= ST_SQCHK;
          end
        end
        ST_ACC: begin
          if (mul_done) begin
            acc   <= mul_res;
            e     <= e >> 1;
            state <= ST_SQCHK;
          end
        end
        ST_SQCHK: begin
          // The last squaring would never be used, so it is skipped.
          if (e == '0) begin
            state <= ST_CHECK;
          end else begin
            squaring <= 1'b1;
            mul_go   <= 1'b1;
            state    <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (mul_done) begin
            base  <= mul_res;
            state <= ST_CHECK;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A finished result always leaves the block free for the next transaction.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while the block is still busy");

  // The done strobe lasts exactly one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // An accepted transaction makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start the sequencer");

  // The product unit only reports completion while a product is awaited.
  a_mul_owned: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_ACC || state == ST_SQ))
    else $error("product finished while the sequencer was not waiting for it");
`endif

endmodule
